[hdl/humidity_temperature_calibrator_unit_assert.svh]
// assertion macros for the humidity and temperature calibrator
// used by the top level; needs a clock and an active-high reset in scope
`ifndef HUMIDITY_TEMPERATURE_CALIBRATOR_UNIT_ASSERT_SVH
`define HUMIDITY_TEMPERATURE_CALIBRATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define HTC_ASSERT_IMP(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("calibrator check failed");

// next-cycle implication
`define HTC_ASSERT_NXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("calibrator check failed");

`endif

[hdl/htc_pkg.sv]
// shared types, constants and the divider step for the calibrator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package htc_pkg;

  localparam int Q_W   = 27;  // quotient bits, one division cell each
  localparam int DVS_W = 16;  // divisor magnitude bits
  localparam int RES_W = 28;  // result width in tenths
  localparam int REF_W = 7;   // calibration point in whole units
  localparam int RAW_W = 16;  // raw sample width
  localparam int SPN_W = 11;  // magnitude of span times ten

  typedef enum logic [2:0] {
    REG_HUM_REF0  = 3'd0,
    REG_HUM_REF1  = 3'd1,
    REG_TEMP_REF0 = 3'd2,
    REG_TEMP_REF1 = 3'd3,
    REG_HUM_C0    = 3'd4,
    REG_HUM_C1    = 3'd5,
    REG_TEMP_C0   = 3'd6,
    REG_TEMP_C1   = 3'd7
  } reg_idx_t;

  // calibration line of one quantity
  typedef struct packed {
    logic        [REF_W-1:0] ref0;
    logic        [REF_W-1:0] ref1;
    logic signed [RAW_W-1:0] c0;
    logic signed [RAW_W-1:0] c1;
  } lane_cfg_t;

  // one lane in flight through the divider
  typedef struct packed {
    logic [DVS_W-1:0] rem;
    logic [Q_W-1:0]   work;
    logic [DVS_W-1:0] dvs;
    logic             neg;
    logic             err;
  } lane_t;

  // word handed from cell to cell
  typedef struct packed {
    lane_t t;
    lane_t h;
  } pair_t;

  // one restoring division step: shift in the next dividend bit, try subtract
  function automatic lane_t div_step(lane_t a);
    lane_t            r;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    r     = a;
    trial = {a.rem, a.work[Q_W-1]};
    diff  = trial - {1'b0, a.dvs};
    if (trial >= {1'b0, a.dvs}) begin
      r.rem  = diff[DVS_W-1:0];
      r.work = {a.work[Q_W-2:0], 1'b1};
    end else begin
      r.rem  = trial[DVS_W-1:0];
      r.work = {a.work[Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

[hdl/htc_prep.sv]
// front end: differences and magnitudes, then the numerator product
// depends on htc_pkg; feeds the first division cell
`timescale 1ns / 1ps

module htc_prep
  import htc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic signed [RAW_W-1:0] raw_humidity,
  input  logic signed [RAW_W-1:0] raw_temperature,
  input  lane_cfg_t               t_cfg,
  input  lane_cfg_t               h_cfg,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output pair_t                   dn_word
);

  typedef struct packed {
    logic [DVS_W-1:0] mag_diff;
    logic [SPN_W-1:0] mag_span;
    logic [DVS_W-1:0] mag_dvs;
    logic             neg;
    logic             err;
  } prep_t;

  typedef struct packed {
    prep_t t;
    prep_t h;
  } prep_pair_t;

  function automatic prep_t prep_lane(logic signed [RAW_W-1:0] raw, lane_cfg_t c);
    prep_t              p;
    logic [RAW_W:0]     diff;
    logic [RAW_W:0]     dvs;
    logic [RAW_W:0]     adiff;
    logic [RAW_W:0]     advs;
    logic [REF_W:0]     span;
    logic [REF_W:0]     aspan;
    logic [SPN_W-1:0]   s;
    diff  = {raw[RAW_W-1], raw} - {c.c0[RAW_W-1], c.c0};
    dvs   = {c.c1[RAW_W-1], c.c1} - {c.c0[RAW_W-1], c.c0};
    span  = {1'b0, c.ref1} - {1'b0, c.ref0};
    adiff = diff[RAW_W] ? -diff : diff;
    advs  = dvs[RAW_W] ? -dvs : dvs;
    aspan = span[REF_W] ? -span : span;
    s     = ({4'b0, aspan[REF_W-1:0]} << 3) + ({4'b0, aspan[REF_W-1:0]} << 1);
    p.mag_diff = adiff[DVS_W-1:0];
    p.mag_span = s;
    p.mag_dvs  = advs[DVS_W-1:0];
    p.neg      = diff[RAW_W] ^ span[REF_W] ^ dvs[RAW_W];
    p.err      = (dvs == '0);
    return p;
  endfunction

  function automatic lane_t mul_lane(prep_t p);
    lane_t l;
    l.rem  = '0;
    // both operands widened to the full quotient width before the product
    l.work = {{(Q_W-DVS_W){1'b0}}, p.mag_diff} * {{(Q_W-SPN_W){1'b0}}, p.mag_span};
    l.dvs  = p.mag_dvs;
    l.neg  = p.neg;
    l.err  = p.err;
    return l;
  endfunction

  logic       a_vld;
  prep_pair_t a_word;
  logic       a_ready;

  assign up_ready = !a_vld || a_ready;
  assign a_ready  = !dn_valid || dn_ready;

  // stage a: subtractions and magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (up_ready) begin
      a_vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      a_word.t <= prep_lane(raw_temperature, t_cfg);
      a_word.h <= prep_lane(raw_humidity, h_cfg);
    end
  end

  // stage b: numerator magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (a_ready) begin
      dn_valid <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && a_vld) begin
      dn_word.t <= mul_lane(a_word.t);
      dn_word.h <= mul_lane(a_word.h);
    end
  end

endmodule

[hdl/htc_div_cell.sv]
// one cell of the divider chain: one quotient bit per lane
// depends on htc_pkg
`timescale 1ns / 1ps

module htc_div_cell
  import htc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  pair_t up_word,
  output logic  dn_valid,
  input  logic  dn_ready,
  output pair_t dn_word
);

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_word.t <= div_step(up_word.t);
      dn_word.h <= div_step(up_word.h);
    end
  end

endmodule

[hdl/htc_post.sv]
// back end: sign, offset and error forcing into the output register
// depends on htc_pkg; fed by the last division cell
`timescale 1ns / 1ps

module htc_post
  import htc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  pair_t                   up_word,
  input  logic [REF_W-1:0]        t_ref0,
  input  logic [REF_W-1:0]        h_ref0,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic signed [RES_W-1:0] t_res,
  output logic signed [RES_W-1:0] h_res,
  output logic                    t_err,
  output logic                    h_err
);

  function automatic logic [RES_W-1:0] finish(lane_t l, logic [REF_W-1:0] ref0);
    logic [RES_W-1:0] q;
    logic [RES_W-1:0] off;
    q   = {1'b0, l.work};
    off = (RES_W'(ref0) << 3) + (RES_W'(ref0) << 1);
    if (l.neg) begin
      q = -q;
    end
    return l.err ? '0 : q + off;
  endfunction

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      t_res <= signed'(finish(up_word.t, t_ref0));
      h_res <= signed'(finish(up_word.h, h_ref0));
      t_err <= up_word.t.err;
      h_err <= up_word.h.err;
    end
  end

endmodule

[hdl/humidity_temperature_calibrator_unit.sv]
// an accepted word passes 2 front-end stages, 27 divider cells and 1 output register
// on its way to its result; throughput: one word per cycle unless out_ready stalls the chain
// the chain of 27 restoring-division cells, one quotient bit each, sets latency
// stalls ripple back only as far as the first empty stage
// reset (synchronous) clears all calibration registers and every valid bit
`timescale 1ns / 1ps
`include "humidity_temperature_calibrator_unit_assert.svh"

module humidity_temperature_calibrator_unit
  import htc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // apb-style configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // sample words
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [15:0]      raw_humidity,
  input  logic signed [15:0]      raw_temperature,
  // calibrated words
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [27:0]      temperature_tenths,
  output logic signed [27:0]      humidity_tenths,
  output logic                    temp_div_error,
  output logic                    hum_div_error
);

  // calibration registers
  logic [7:0]  hum_ref0_x2;
  logic [7:0]  hum_ref1_x2;
  logic [9:0]  temp_ref0_x8;
  logic [9:0]  temp_ref1_x8;
  logic [15:0] hum_c0;
  logic [15:0] hum_c1;
  logic [15:0] temp_c0;
  logic [15:0] temp_c1;

  reg_idx_t  widx;
  logic      wr_en;
  lane_cfg_t t_cfg;
  lane_cfg_t h_cfg;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hum_ref0_x2  <= '0;
      hum_ref1_x2  <= '0;
      temp_ref0_x8 <= '0;
      temp_ref1_x8 <= '0;
      hum_c0       <= '0;
      hum_c1       <= '0;
      temp_c0      <= '0;
      temp_c1      <= '0;
    end else if (wr_en) begin
      // upper data bits beyond each register are dropped
      unique case (widx)
        REG_HUM_REF0:  hum_ref0_x2  <= pwdata[7:0];
        REG_HUM_REF1:  hum_ref1_x2  <= pwdata[7:0];
        REG_TEMP_REF0: temp_ref0_x8 <= pwdata[9:0];
        REG_TEMP_REF1: temp_ref1_x8 <= pwdata[9:0];
        REG_HUM_C0:    hum_c0       <= pwdata[15:0];
        REG_HUM_C1:    hum_c1       <= pwdata[15:0];
        REG_TEMP_C0:   temp_c0      <= pwdata[15:0];
        REG_TEMP_C1:   temp_c1      <= pwdata[15:0];
        default:       hum_ref0_x2  <= hum_ref0_x2;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (widx)
      REG_HUM_REF0:  prdata = {24'b0, hum_ref0_x2};
      REG_HUM_REF1:  prdata = {24'b0, hum_ref1_x2};
      REG_TEMP_REF0: prdata = {22'b0, temp_ref0_x8};
      REG_TEMP_REF1: prdata = {22'b0, temp_ref1_x8};
      REG_HUM_C0:    prdata = {16'b0, hum_c0};
      REG_HUM_C1:    prdata = {16'b0, hum_c1};
      REG_TEMP_C0:   prdata = {16'b0, temp_c0};
      REG_TEMP_C1:   prdata = {16'b0, temp_c1};
      default:       prdata = '0;
    endcase
  end

  // whole units: degrees are x8 >> 3, percent is x2 >> 1
  assign t_cfg.ref0 = temp_ref0_x8[9:3];
  assign t_cfg.ref1 = temp_ref1_x8[9:3];
  assign t_cfg.c0   = signed'(temp_c0);
  assign t_cfg.c1   = signed'(temp_c1);
  assign h_cfg.ref0 = hum_ref0_x2[7:1];
  assign h_cfg.ref1 = hum_ref1_x2[7:1];
  assign h_cfg.c0   = signed'(hum_c0);
  assign h_cfg.c1   = signed'(hum_c1);

  // chain links: index 0 is the front-end output, Q_W the last cell output
  pair_t cell_word [0:Q_W];
  logic  cell_vld  [0:Q_W];
  logic  cell_rdy  [0:Q_W];

  // front end: |raw - c0|, |span| * 10, |c1 - c0|, then the numerator product
  htc_prep u_prep (
    .clk             (clk),
    .rst             (rst),
    .up_valid        (in_valid),
    .up_ready        (in_ready),
    .raw_humidity    (raw_humidity),
    .raw_temperature (raw_temperature),
    .t_cfg           (t_cfg),
    .h_cfg           (h_cfg),
    .dn_valid        (cell_vld[0]),
    .dn_ready        (cell_rdy[0]),
    .dn_word         (cell_word[0])
  );

  // divider chain, msb of the quotient first
  for (genvar i = 0; i < Q_W; i++) begin : g_cell
    htc_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (cell_vld[i]),
      .up_ready (cell_rdy[i]),
      .up_word  (cell_word[i]),
      .dn_valid (cell_vld[i+1]),
      .dn_ready (cell_rdy[i+1]),
      .dn_word  (cell_word[i+1])
    );
  end

  // sign, ref0 * 10 offset, zero on a zero divisor
  htc_post u_post (
    .clk      (clk),
    .rst      (rst),
    .up_valid (cell_vld[Q_W]),
    .up_ready (cell_rdy[Q_W]),
    .up_word  (cell_word[Q_W]),
    .t_ref0   (t_cfg.ref0),
    .h_ref0   (h_cfg.ref0),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .t_res    (temperature_tenths),
    .h_res    (humidity_tenths),
    .t_err    (temp_div_error),
    .h_err    (hum_div_error)
  );

  // a flagged quantity always reads zero
  `HTC_ASSERT_IMP(a_temp_err_zero, clk, rst, out_valid && temp_div_error, temperature_tenths == '0)
  `HTC_ASSERT_IMP(a_hum_err_zero, clk, rst, out_valid && hum_div_error, humidity_tenths == '0)
  // a count register write lands on the next edge
  `HTC_ASSERT_NXT(a_cfg_write, clk, rst, wr_en && (widx == REG_TEMP_C1), temp_c1 == $past(pwdata[15:0]))

endmodule

[sim/tb.sv]
// testbench for humidity_temperature_calibrator_unit: bit-exact prediction of both lanes
// depends on htc_pkg (hdl/htc_pkg.sv) and the calibrator rtl; reads no files
`timescale 1ns / 1ps

module tb;
  import htc_pkg::*;

  localparam int LATENCY        = 30;    // accepted word to its result
  localparam int SETTLE_CYCLES  = LATENCY + 10;
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer of any kind

  // one calibrated word as the block presents it
  typedef struct packed {
    logic signed [27:0] temp_tenths;
    logic signed [27:0] hum_tenths;
    logic               temp_err;
    logic               hum_err;
  } cal_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [4:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  wire  [31:0] prdata;
  wire         pready;

  logic               in_valid        = 1'b0;
  wire                in_ready;
  logic signed [15:0] raw_humidity    = '0;
  logic signed [15:0] raw_temperature = '0;

  wire                out_valid;
  logic               out_ready = 1'b0;
  wire signed [27:0]  temperature_tenths;
  wire signed [27:0]  humidity_tenths;
  wire                temp_div_error;
  wire                hum_div_error;

  // shadow of the calibration registers, already trimmed to register width
  logic [15:0] cal_shadow [8];

  // calibrated words still owed by the block, oldest first
  cal_word_t pending_words [$];

  int   mismatch_count = 0;
  int   idle_cycles    = 0;
  int   send_idle_pct  = 0;
  int   recv_idle_pct  = 0;
  logic stall_request  = 1'b0;

  humidity_temperature_calibrator_unit u_top (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .raw_humidity       (raw_humidity),
    .raw_temperature    (raw_temperature),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .temperature_tenths (temperature_tenths),
    .humidity_tenths    (humidity_tenths),
    .temp_div_error     (temp_div_error),
    .hum_div_error      (hum_div_error)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // calibration arithmetic
  // ---------------------------------------------------------------------------

  // bits each register keeps; the rest of a write is dropped
  function automatic logic [31:0] field_mask(input reg_idx_t idx);
    case (idx)
      REG_HUM_REF0, REG_HUM_REF1:   return 32'h0000_00ff;
      REG_TEMP_REF0, REG_TEMP_REF1: return 32'h0000_03ff;
      default:                      return 32'h0000_ffff;
    endcase
  endfunction

  // straight line through (cnt0, pt0) and (cnt1, pt1), in tenths;
  // signed longint division truncates toward zero, as the block must
  function automatic longint line_tenths(input longint raw, input longint pt0,
                                         input longint pt1, input longint cnt0,
                                         input longint cnt1, output logic err);
    longint span;
    span = cnt1 - cnt0;
    err  = (span == 0);
    if (err)
      return 0;
    return (raw - cnt0) * (pt1 - pt0) * 10 / span + pt0 * 10;
  endfunction

  // expected word for one sample under the current calibration
  function automatic cal_word_t calibrate_sample(input logic signed [15:0] rh,
                                                 input logic signed [15:0] rt);
    cal_word_t w;
    longint    t;
    longint    h;
    logic      te;
    logic      he;
    // whole degrees are x8 >> 3, whole percent is x2 >> 1
    t = line_tenths(longint'(rt),
                    longint'(cal_shadow[REG_TEMP_REF0] >> 3),
                    longint'(cal_shadow[REG_TEMP_REF1] >> 3),
                    longint'($signed(cal_shadow[REG_TEMP_C0])),
                    longint'($signed(cal_shadow[REG_TEMP_C1])), te);
    h = line_tenths(longint'(rh),
                    longint'(cal_shadow[REG_HUM_REF0] >> 1),
                    longint'(cal_shadow[REG_HUM_REF1] >> 1),
                    longint'($signed(cal_shadow[REG_HUM_C0])),
                    longint'($signed(cal_shadow[REG_HUM_C1])), he);
    w.temp_tenths = t[27:0];
    w.hum_tenths  = h[27:0];
    w.temp_err    = te;
    w.hum_err     = he;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input longint got, input longint want);
    mismatch_count++;
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, field, got, want);
  endtask

  // input words are predicted at acceptance; output words are checked in order
  always @(posedge clk) begin : check_words
    cal_word_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        pending_words.push_back(calibrate_sample(raw_humidity, raw_temperature));
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          report_mismatch("word with nothing pending", temperature_tenths, 0);
        end else begin
          want = pending_words.pop_front();
          if (temperature_tenths !== want.temp_tenths)
            report_mismatch("temperature_tenths", temperature_tenths, want.temp_tenths);
          if (humidity_tenths !== want.hum_tenths)
            report_mismatch("humidity_tenths", humidity_tenths, want.hum_tenths);
          if (temp_div_error !== want.temp_err)
            report_mismatch("temp_div_error", temp_div_error, want.temp_err);
          if (hum_div_error !== want.hum_err)
            report_mismatch("hum_div_error", hum_div_error, want.hum_err);
        end
      end
    end
  end

  // watchdog: a run that stops moving ends as a failure
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, or one long hold-off when asked for
  initial begin
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request <= 1'b0;
        out_ready     <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // apb write: setup phase, access phase held until pready, then an idle bus;
  // bits above the register width carry random junk
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] keep;
    keep = field_mask(idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (value & keep) | ($urandom() & ~keep);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cal_shadow[idx] = 16'(value & keep);
    @(posedge clk);
  endtask

  // writes all eight registers; counts may be given as negative ints
  task automatic load_lines(input int h0_x2, input int h1_x2, input int t0_x8,
                            input int t1_x8, input int hc0, input int hc1,
                            input int tc0, input int tc1);
    write_reg(REG_HUM_REF0, h0_x2);
    write_reg(REG_HUM_REF1, h1_x2);
    write_reg(REG_TEMP_REF0, t0_x8);
    write_reg(REG_TEMP_REF1, t1_x8);
    write_reg(REG_HUM_C0, hc0);
    write_reg(REG_HUM_C1, hc1);
    write_reg(REG_TEMP_C0, tc0);
    write_reg(REG_TEMP_C1, tc1);
  endtask

  // one sample word; valid stays high across back-to-back words
  // samples may be given as negative ints, only the low 16 bits are sent
  task automatic send_sample(input int rh, input int rt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    raw_humidity    <= 16'(rh);
    raw_temperature <= 16'(rt);
    do @(posedge clk); while (!in_ready);
  endtask

  // sender pauses until the block has returned everything it owes
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // block fully idle: safe point for register writes
  task automatic settle_block();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // random shaping
  // ---------------------------------------------------------------------------

  function automatic int pick_point(input int top);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  // count pair: equal (error lane), unit divisor, full span or random
  function automatic void pick_counts(output logic [15:0] c0, output logic [15:0] c1);
    c0 = 16'($urandom());
    case ($urandom_range(0, 7))
      0: c1 = c0;
      1: c1 = c0 + 16'd1;
      2: c1 = c0 - 16'd1;
      3: begin
        c0 = 16'h8000;
        c1 = 16'h7fff;
      end
      4: begin
        c0 = 16'h7fff;
        c1 = 16'h8000;
      end
      default: c1 = 16'($urandom());
    endcase
  endfunction

  // raw sample: mostly anywhere, sometimes at the rails or near a calibration count
  function automatic logic [15:0] pick_raw(input logic [15:0] c0, input logic [15:0] c1);
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return c0 ^ 16'($urandom_range(0, 3));
      3:       return c1;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic load_random_lines();
    logic [15:0] hc0;
    logic [15:0] hc1;
    logic [15:0] tc0;
    logic [15:0] tc1;
    pick_counts(hc0, hc1);
    pick_counts(tc0, tc1);
    load_lines(pick_point(255), pick_point(255), pick_point(1023), pick_point(1023),
               hc0, hc1, tc0, tc1);
  endtask

  task automatic send_random_samples(input int count);
    repeat (count)
      send_sample(int'(pick_raw(cal_shadow[REG_HUM_C0], cal_shadow[REG_HUM_C1])),
                  int'(pick_raw(cal_shadow[REG_TEMP_C0], cal_shadow[REG_TEMP_C1])));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // all registers zero after reset: both divisors are zero
  task automatic test_reset_state();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_sample(-32768, 32767);
    send_sample(32767, -32768);
    settle_block();
  endtask

  task automatic test_corner_lines();
    // widest count span, widest reference span, humidity line falling
    load_lines(255, 0, 0, 1023, -32768, 32767, -32768, 32767);
    send_sample(-32768, -32768);
    send_sample(32767, 32767);
    send_sample(0, -1);
    send_sample(-1, 0);
    settle_block();
    // divisor of one in magnitude: largest products the lanes can see
    load_lines(255, 0, 1023, 0, 32767, 32766, -32768, -32767);
    send_sample(-32768, 32767);
    send_sample(32767, -32768);
    send_sample(12345, -12345);
    send_sample(0, 0);
    settle_block();
    // divisor of three, one-unit span: quotient must truncate toward zero
    load_lines(0, 2, 0, 8, 0, 3, 0, -3);
    send_sample(-1, -1);
    send_sample(1, 1);
    send_sample(-2, 2);
    send_sample(-4, 4);
    settle_block();
    // temperature counts equal, humidity lane still calibrated
    load_lines(40, 200, 80, 800, -1000, 1000, 777, 777);
    send_sample(777, 777);
    send_sample(-32768, 32767);
    send_sample(500, -500);
    settle_block();
    // humidity counts equal, temperature lane still calibrated
    load_lines(40, 200, 80, 800, -5, -5, -1000, 1000);
    send_sample(-5, -5);
    send_sample(32767, -32768);
    send_sample(-500, 500);
    settle_block();
  endtask

  task automatic test_random_traffic(input int sets, input int per_set,
                                     input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (sets) begin
      load_random_lines();
      send_random_samples(per_set);
      settle_block();
    end
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input,
  // then the sender stops once mid-stream until the pipeline has emptied
  task automatic test_stall_and_pause();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_random_lines();
    stall_request <= 1'b1;
    send_random_samples(50);
    wait_for_results();
    send_random_samples(30);
    settle_block();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_corner_lines();
    test_random_traffic(6, 50, 17, 81);
    test_random_traffic(6, 50, 81, 17);
    test_stall_and_pause();
    test_random_traffic(5, 50, 0, 0);

    settle_block();
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/htc_pkg.sv
hdl/htc_prep.sv
hdl/htc_div_cell.sv
hdl/htc_post.sv
hdl/humidity_temperature_calibrator_unit.sv
sim/tb.sv
